/* rtl/gtl_pkg.sv */
// Shared types, constants and helpers for the grid tile layout block.
package gtl_pkg;

  localparam int CNT_W      = 5;
  localparam int ROWS_W     = 4;
  localparam int DIM_W      = 14;
  localparam int COORD_W    = 16;
  localparam int GAP_W      = 10;
  localparam int MARG_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Reciprocal of 3 for a 14-bit dividend: q = (v * RECIP3) >> RECIP3_SHIFT
  localparam int RECIP_W      = 16;
  localparam int RECIP3_SHIFT = 17;
  localparam logic [RECIP_W-1:0] RECIP3 = 16'd43691;
  localparam int PROD_W       = DIM_W + RECIP_W;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ROWS_W-1:0]  rows_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [1:0]         cols_t;

  localparam cols_t COLS_ONE   = 2'd1;
  localparam cols_t COLS_TWO   = 2'd2;
  localparam cols_t COLS_THREE = 2'd3;

  // Row patterns for counts 4, 5 and 6, indexed by count[1:0]
  localparam cols_t SMALL_ROWS [3][2] = '{
    '{COLS_TWO,   COLS_TWO},
    '{COLS_TWO,   COLS_THREE},
    '{COLS_THREE, COLS_THREE}
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MARGIN_LEFT   = 3'd0,
    CFG_MARGIN_RIGHT  = 3'd1,
    CFG_MARGIN_TOP    = 3'd2,
    CFG_MARGIN_BOTTOM = 3'd3,
    CFG_TILE_GAP      = 3'd4,
    CFG_SCREEN_WIDTH  = 3'd5,
    CFG_SCREEN_HEIGHT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [MARG_W-1:0] margin_left;
    logic [MARG_W-1:0] margin_right;
    logic [MARG_W-1:0] margin_top;
    logic [MARG_W-1:0] margin_bottom;
    logic [GAP_W-1:0]  tile_gap;
    dim_t              screen_width;
    dim_t              screen_height;
  } cfg_t;

  // One layout request after classification
  typedef struct packed {
    cnt_t  cnt;
    dim_t  usable_w;
    dim_t  h_base;
    rows_t h_rem;
  } job_t;

  typedef struct packed {
    coord_t tile_x;
    coord_t tile_y;
    dim_t   tile_width;
    dim_t   tile_height;
    logic   last_tile;
  } tile_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_PREP,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROW,
    BK_MUL,
    BK_SPLIT,
    BK_TILE
  } back_state_t;

  // Number of rows for a nonzero count: 2 for counts 4..6, else ceil(count/3)
  function automatic rows_t rows_for(input cnt_t cnt);
    logic [10:0] prod;
    prod = (11'(cnt) + 11'd2) * 11'd43;
    if (cnt inside {[5'd4:5'd6]}) begin
      return rows_t'(2);
    end
    return rows_t'(prod >> 7);
  endfunction

endpackage

/* rtl/gtl_fifo.sv */
// Small first-word-fall-through queue built from registers.
module gtl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W + 1)'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == DEPTH_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/gtl_front.sv */
// Front end: takes a request, sizes the usable area and splits the height by rows.
module gtl_front #(
  parameter int MAX_WINDOWS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gtl_pkg::cfg_t cfg,
  input  logic          push,
  input  gtl_pkg::cnt_t window_count,
  output logic          full,
  output logic          job_push,
  output gtl_pkg::job_t job,
  input  logic          job_full
);

  localparam int CNT_CAP  = (MAX_WINDOWS < 31) ? MAX_WINDOWS : 31;
  localparam int BITCNT_W = $clog2(gtl_pkg::DIM_W);
  localparam logic [BITCNT_W-1:0] LAST_BIT = BITCNT_W'(gtl_pkg::DIM_W - 1);

  gtl_pkg::front_state_t state_r, state_nxt;

  gtl_pkg::cnt_t          cnt_sat;
  gtl_pkg::cnt_t          cnt_r;
  gtl_pkg::rows_t         nrows_r;
  gtl_pkg::dim_t          usable_w_r;
  gtl_pkg::dim_t          quo_r;
  logic [gtl_pkg::ROWS_W:0] rem_r;
  logic [BITCNT_W-1:0]    bit_cnt_r;

  logic [gtl_pkg::DIM_W-1:0] lr_sum;
  logic [gtl_pkg::DIM_W-1:0] tb_sum;
  gtl_pkg::dim_t          usable_w;
  gtl_pkg::dim_t          inner_h;
  gtl_pkg::dim_t          gap_h;
  gtl_pkg::dim_t          usable_h;
  logic [gtl_pkg::ROWS_W:0] rem_sh;
  logic [gtl_pkg::ROWS_W:0] divisor;
  logic                   ge;
  logic                   accept;

  assign cnt_sat = (int'(window_count) > CNT_CAP) ? gtl_pkg::cnt_t'(CNT_CAP) : window_count;
  assign accept  = push && (state_r == gtl_pkg::FR_IDLE);

  // Usable area; each size clamps at zero
  assign lr_sum   = gtl_pkg::DIM_W'(cfg.margin_left) + gtl_pkg::DIM_W'(cfg.margin_right);
  assign tb_sum   = gtl_pkg::DIM_W'(cfg.margin_top) + gtl_pkg::DIM_W'(cfg.margin_bottom);
  assign usable_w = (cfg.screen_width > lr_sum) ? cfg.screen_width - lr_sum : '0;
  assign inner_h  = (cfg.screen_height > tb_sum) ? cfg.screen_height - tb_sum : '0;
  assign gap_h    = gtl_pkg::DIM_W'(cfg.tile_gap) * gtl_pkg::DIM_W'(nrows_r - 1'b1);
  assign usable_h = (inner_h > gap_h) ? inner_h - gap_h : '0;

  // One quotient bit per cycle
  assign divisor = {1'b0, nrows_r};
  assign rem_sh  = {rem_r[gtl_pkg::ROWS_W-1:0], quo_r[gtl_pkg::DIM_W-1]};
  assign ge      = (rem_sh >= divisor);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gtl_pkg::FR_IDLE: begin
        if (push && cnt_sat != '0) begin
          state_nxt = gtl_pkg::FR_PREP;
        end
      end
      gtl_pkg::FR_PREP: state_nxt = gtl_pkg::FR_DIV;
      gtl_pkg::FR_DIV: begin
        if (bit_cnt_r == '0) begin
          state_nxt = gtl_pkg::FR_PUSH;
        end
      end
      gtl_pkg::FR_PUSH: begin
        if (!job_full) begin
          state_nxt = gtl_pkg::FR_IDLE;
        end
      end
      default: state_nxt = gtl_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    full     = (state_r != gtl_pkg::FR_IDLE);
    job_push = (state_r == gtl_pkg::FR_PUSH) && !job_full;
  end

  assign job.cnt      = cnt_r;
  assign job.usable_w = usable_w_r;
  assign job.h_base   = quo_r;
  assign job.h_rem    = rem_r[gtl_pkg::ROWS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtl_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r   <= cnt_sat;
      nrows_r <= gtl_pkg::rows_for(cnt_sat);
    end
    case (state_r)
      gtl_pkg::FR_PREP: begin
        usable_w_r <= usable_w;
        quo_r      <= usable_h;
        rem_r      <= '0;
        bit_cnt_r  <= LAST_BIT;
      end
      gtl_pkg::FR_DIV: begin
        rem_r     <= ge ? rem_sh - divisor : rem_sh;
        quo_r     <= {quo_r[gtl_pkg::DIM_W-2:0], ge};
        bit_cnt_r <= bit_cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/gtl_back.sv */
// Back end: walks the rows of a job and emits one rectangle per window.
module gtl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  gtl_pkg::cfg_t  cfg,
  input  logic           job_empty,
  input  gtl_pkg::job_t  job,
  output logic           job_pop,
  output logic           tile_push,
  output gtl_pkg::tile_t tile,
  input  logic           tile_full
);

  gtl_pkg::back_state_t state_r, state_nxt;

  gtl_pkg::job_t   job_r;
  gtl_pkg::rows_t  row_r;
  gtl_pkg::cnt_t   left_r;
  gtl_pkg::cols_t  col_r;
  gtl_pkg::cols_t  cols_r;
  gtl_pkg::dim_t   row_w_r;
  gtl_pkg::dim_t   h_r;
  logic [gtl_pkg::PROD_W-1:0] prod_r;
  gtl_pkg::dim_t   w_base_r;
  gtl_pkg::cols_t  w_rem_r;
  gtl_pkg::coord_t x_r;
  gtl_pkg::coord_t y_r;

  gtl_pkg::cols_t  cols;
  gtl_pkg::dim_t   gap_w;
  gtl_pkg::dim_t   row_w;
  gtl_pkg::dim_t   h;
  gtl_pkg::dim_t   q;
  gtl_pkg::cols_t  w_rem;
  gtl_pkg::dim_t   w;
  logic            last;
  logic            row_done;
  logic            emit;

  // Tiles in the current row
  always_comb begin
    if (job_r.cnt inside {[5'd4:5'd6]}) begin
      cols = gtl_pkg::SMALL_ROWS[job_r.cnt[1:0]][row_r[0]];
    end else if (left_r >= gtl_pkg::cnt_t'(3)) begin
      cols = gtl_pkg::COLS_THREE;
    end else begin
      cols = left_r[1:0];
    end
  end

  assign gap_w = (cols == gtl_pkg::COLS_THREE) ? gtl_pkg::DIM_W'({cfg.tile_gap, 1'b0}) :
                 (cols == gtl_pkg::COLS_TWO)   ? gtl_pkg::DIM_W'(cfg.tile_gap) : '0;
  assign row_w = (job_r.usable_w > gap_w) ? job_r.usable_w - gap_w : '0;
  assign h     = job_r.h_base + gtl_pkg::DIM_W'(row_r < job_r.h_rem);

  // Split the row width over 1, 2 or 3 tiles
  always_comb begin
    case (cols_r)
      gtl_pkg::COLS_THREE: begin
        q     = gtl_pkg::DIM_W'(prod_r >> gtl_pkg::RECIP3_SHIFT);
        w_rem = 2'(row_w_r - {q[gtl_pkg::DIM_W-2:0], 1'b0} - q);
      end
      gtl_pkg::COLS_TWO: begin
        q     = row_w_r >> 1;
        w_rem = {1'b0, row_w_r[0]};
      end
      default: begin
        q     = row_w_r;
        w_rem = '0;
      end
    endcase
  end

  assign w        = w_base_r + gtl_pkg::DIM_W'(col_r < w_rem_r);
  assign last     = (left_r == gtl_pkg::cnt_t'(1));
  assign row_done = (col_r == cols_r - 1'b1);
  assign emit     = (state_r == gtl_pkg::BK_TILE) && !tile_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gtl_pkg::BK_IDLE: begin
        if (!job_empty) begin
          state_nxt = gtl_pkg::BK_ROW;
        end
      end
      gtl_pkg::BK_ROW:   state_nxt = gtl_pkg::BK_MUL;
      gtl_pkg::BK_MUL:   state_nxt = gtl_pkg::BK_SPLIT;
      gtl_pkg::BK_SPLIT: state_nxt = gtl_pkg::BK_TILE;
      gtl_pkg::BK_TILE: begin
        if (!tile_full) begin
          if (last) begin
            state_nxt = gtl_pkg::BK_IDLE;
          end else if (row_done) begin
            state_nxt = gtl_pkg::BK_ROW;
          end
        end
      end
      default: state_nxt = gtl_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = (state_r == gtl_pkg::BK_IDLE) && !job_empty;
    tile_push = emit;
  end

  // Coordinates stay below 65536 for every register setting, so no clipping is needed
  assign tile.tile_x      = x_r;
  assign tile.tile_y      = y_r;
  assign tile.tile_width  = w;
  assign tile.tile_height = h_r;
  assign tile.last_tile   = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtl_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      gtl_pkg::BK_IDLE: begin
        job_r  <= job;
        left_r <= job.cnt;
        row_r  <= '0;
        y_r    <= gtl_pkg::COORD_W'(cfg.margin_top);
      end
      gtl_pkg::BK_ROW: begin
        cols_r  <= cols;
        row_w_r <= row_w;
        h_r     <= h;
        col_r   <= '0;
        x_r     <= gtl_pkg::COORD_W'(cfg.margin_left);
      end
      gtl_pkg::BK_MUL: begin
        prod_r <= row_w_r * gtl_pkg::RECIP3;
      end
      gtl_pkg::BK_SPLIT: begin
        w_base_r <= q;
        w_rem_r  <= w_rem;
      end
      gtl_pkg::BK_TILE: begin
        if (emit) begin
          x_r    <= x_r + gtl_pkg::COORD_W'(w) + gtl_pkg::COORD_W'(cfg.tile_gap);
          col_r  <= col_r + 1'b1;
          left_r <= left_r - 1'b1;
          if (row_done) begin
            y_r   <= y_r + gtl_pkg::COORD_W'(h_r) + gtl_pkg::COORD_W'(cfg.tile_gap);
            row_r <= row_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/grid_tile_layout.sv */
// Top level of the grid tile layout block: config registers, front, job queue, back, result queue.
//
// Usage: write the seven layout registers through cfg_wr_en/cfg_index/cfg_wdata while the
// block is idle; indexes past the list are dropped. A request beat (window count) is taken
// when push is high and full is low. The block answers with one rectangle beat per window,
// in window order, through a result queue: the oldest rectangle sits on out_* while empty
// is low and leaves on a cycle with pop high. last_tile marks the final beat of a request.
// A count of zero is taken and produces nothing; counts above MAX_WINDOWS saturate.
// Flow: the front holds full per request through one setup step, a bit-serial division of
// the usable height by the row count and one push into the job queue, so it takes no new
// request until the last one is in the job queue. The back takes a job, then for each row
// steps through width, reciprocal multiply and split before it emits one tile per window.
// A two-beat job queue lets the front take the next request while the back still works.
// When the receiver stops popping, the result queue fills, the back waits, and the front
// stays in its push step with full high once the job queue is also full; nothing is
// dropped. Reset empties both queues, returns both sequencers to idle and loads the
// registers with zero margins and gap and a 1920 x 1080 screen.
module grid_tile_layout #(
  parameter int MAX_WINDOWS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [gtl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             push,
  output logic                             full,
  input  logic [gtl_pkg::CNT_W-1:0]        in_window_count,
  output logic                             empty,
  input  logic                             pop,
  output logic [gtl_pkg::COORD_W-1:0]      out_tile_x,
  output logic [gtl_pkg::COORD_W-1:0]      out_tile_y,
  output logic [gtl_pkg::DIM_W-1:0]        out_tile_width,
  output logic [gtl_pkg::DIM_W-1:0]        out_tile_height,
  output logic                             out_last_tile
);

  localparam int JOB_DEPTH  = 2;
  localparam int TILE_DEPTH = 2;
  localparam int JOB_BITS   = $bits(gtl_pkg::job_t);
  localparam int TILE_BITS  = $bits(gtl_pkg::tile_t);

  gtl_pkg::cfg_t  cfg_r;

  logic           job_push;
  logic           job_full;
  logic           job_pop;
  logic           job_empty;
  gtl_pkg::job_t  job_in;
  gtl_pkg::job_t  job_out;
  logic [JOB_BITS-1:0] job_out_bits;

  logic           tile_push;
  logic           tile_full;
  gtl_pkg::tile_t tile_in;
  gtl_pkg::tile_t tile_out;
  logic [TILE_BITS-1:0] tile_out_bits;

  // Layout registers: user must write values only while no request is in flight; no check here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.margin_left   <= '0;
      cfg_r.margin_right  <= '0;
      cfg_r.margin_top    <= '0;
      cfg_r.margin_bottom <= '0;
      cfg_r.tile_gap      <= '0;
      cfg_r.screen_width  <= gtl_pkg::DIM_W'(1920);
      cfg_r.screen_height <= gtl_pkg::DIM_W'(1080);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gtl_pkg::CFG_MARGIN_LEFT:   cfg_r.margin_left   <= cfg_wdata[gtl_pkg::MARG_W-1:0];
        gtl_pkg::CFG_MARGIN_RIGHT:  cfg_r.margin_right  <= cfg_wdata[gtl_pkg::MARG_W-1:0];
        gtl_pkg::CFG_MARGIN_TOP:    cfg_r.margin_top    <= cfg_wdata[gtl_pkg::MARG_W-1:0];
        gtl_pkg::CFG_MARGIN_BOTTOM: cfg_r.margin_bottom <= cfg_wdata[gtl_pkg::MARG_W-1:0];
        gtl_pkg::CFG_TILE_GAP:      cfg_r.tile_gap      <= cfg_wdata[gtl_pkg::GAP_W-1:0];
        gtl_pkg::CFG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_wdata[gtl_pkg::DIM_W-1:0];
        gtl_pkg::CFG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_wdata[gtl_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: classify the request, size the area, divide the height
  gtl_front #(
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .push         (push),
    .window_count (in_window_count),
    .full         (full),
    .job_push     (job_push),
    .job          (job_in),
    .job_full     (job_full)
  );

  gtl_fifo #(
    .WIDTH (JOB_BITS),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out_bits),
    .empty (job_empty)
  );

  assign job_out = gtl_pkg::job_t'(job_out_bits);

  // Back: row walk and per-tile output
  gtl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .tile_push (tile_push),
    .tile      (tile_in),
    .tile_full (tile_full)
  );

  // Result queue decouples the back from the receiver
  gtl_fifo #(
    .WIDTH (TILE_BITS),
    .DEPTH (TILE_DEPTH)
  ) u_tile_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tile_push),
    .din   (tile_in),
    .full  (tile_full),
    .pop   (pop),
    .dout  (tile_out_bits),
    .empty (empty)
  );

  assign tile_out        = gtl_pkg::tile_t'(tile_out_bits);
  assign out_tile_x      = tile_out.tile_x;
  assign out_tile_y      = tile_out.tile_y;
  assign out_tile_width  = tile_out.tile_width;
  assign out_tile_height = tile_out.tile_height;
  assign out_last_tile   = tile_out.last_tile;

endmodule
